### design/kis_pkg.sv
// ----------------------------------------------------------------------------
// kis_pkg
// Shared types and constants for the keyframe index and seek block.
// ----------------------------------------------------------------------------
package kis_pkg;

   localparam int unsigned TS_W       = 32;
   localparam int unsigned LEN_W      = 32;
   localparam int unsigned RLEN_W     = 24;
   localparam int unsigned STYPE_W    = 16;
   localparam int unsigned FLAGS_W    = 32;
   localparam int unsigned PROG_W     = 10;
   localparam int unsigned SCALE_W    = 10;
   localparam int unsigned PROD_W     = TS_W + SCALE_W;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 112;

   localparam logic [SCALE_W-1:0] PROGRESS_SCALE = 10'd1000;
   localparam logic [PROG_W-1:0]  PROGRESS_MAX   = 10'd1001;
   localparam logic [TS_W-1:0]    DURATION_RESET = 32'd99999000;

   localparam logic [CSR_ADDR_W-1:0] REG_VIDEO_TYPE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY_MASK   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DURATION   = 2'd2;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_SEEK   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

### design/kis_ram.sv
// ----------------------------------------------------------------------------
// kis_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module kis_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/kis_div.sv
// ----------------------------------------------------------------------------
// kis_div
// Restoring divider, one quotient bit per cycle, for the progress value.
// ----------------------------------------------------------------------------
module kis_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [kis_pkg::PROD_W-1:0]   dividend,
   input  logic [kis_pkg::TS_W-1:0]     divisor,
   output logic                         done,
   output logic [kis_pkg::PROD_W-1:0]   quotient
);

   localparam int unsigned CNT_W = $clog2(kis_pkg::PROD_W);

   logic [kis_pkg::TS_W:0]        rem_ff, rem_in;
   logic [kis_pkg::PROD_W-1:0]    quo_ff, quo_in;
   logic [kis_pkg::TS_W-1:0]      dsr_ff, dsr_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [kis_pkg::TS_W:0]        shifted;
   logic [kis_pkg::TS_W+1:0]      diff;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff[kis_pkg::TS_W-1:0], quo_ff[kis_pkg::PROD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = ~diff[kis_pkg::TS_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[kis_pkg::TS_W:0] : shifted;
         quo_in = {quo_ff[kis_pkg::PROD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(kis_pkg::PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/keyframe_index_seek.sv
// ----------------------------------------------------------------------------
// keyframe_index_seek
// Keyframe index with append on video keyframes, backward seek scan and
// download progress tracking.
// ----------------------------------------------------------------------------
// A new request is taken only in the idle state. A frame record returns to idle
// once its result is out, after the progress division (42 quotient bits, one per
// cycle) when the duration is nonzero. A seek reads k index entries backward
// through the single RAM read port (k is 0 for an empty index and at most
// INDEX_DEPTH). A result that is still waiting stalls the next one. Synchronous
// reset restores state, counters and control registers, not datapath or RAM.
module keyframe_index_seek #(
   parameter int unsigned INDEX_DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // stream_type, frame_flags, timestamp, record_length
   input  logic [kis_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // seek_offset, seek_timestamp, progress, progress_changed, index_full,
   // file_length, zero padding
   output logic [kis_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [kis_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [kis_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned AW  = $clog2(INDEX_DEPTH);
   localparam int unsigned CW  = $clog2(INDEX_DEPTH + 1);
   localparam int unsigned MW  = 2 * kis_pkg::TS_W;

   kis_pkg::state_type state_ff, state_in;

   logic [kis_pkg::STYPE_W-1:0] vtype_ff;
   logic [kis_pkg::FLAGS_W-1:0] kmask_ff;
   logic [kis_pkg::TS_W-1:0]    dur_ff;

   logic [CW-1:0]               count_ff, count_in;
   logic [kis_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [kis_pkg::TS_W-1:0]    latest_ff, latest_in;
   logic [kis_pkg::PROG_W-1:0]  lastp_ff, lastp_in;

   logic [kis_pkg::TS_W-1:0]    target_ff, target_in;
   logic [AW-1:0]               pick_ff, pick_in;
   logic                        take_ff, take_in;
   logic [kis_pkg::TS_W-1:0]    soff_ff, soff_in;
   logic [kis_pkg::TS_W-1:0]    sts_ff, sts_in;
   logic                        chg_ff, chg_in;
   logic                        full_ff, full_in;
   logic [kis_pkg::PROD_W-1:0]  prod_ff, prod_in;

   logic                        ovld_ff, ovld_in;
   logic [kis_pkg::RSP_DATA_W-1:0] odata_ff, odata_in;
   logic                        div_go_ff;

   logic [kis_pkg::STYPE_W-1:0] f_stype;
   logic [kis_pkg::FLAGS_W-1:0] f_flags;
   logic [kis_pkg::TS_W-1:0]    f_ts;
   logic [kis_pkg::RLEN_W-1:0]  f_rlen;

   logic                        accept;
   logic                        is_key;
   logic                        wr_en;
   logic [MW-1:0]               wr_data;
   logic [MW-1:0]               rd_data;
   logic [kis_pkg::TS_W-1:0]    rd_ts;
   logic [kis_pkg::TS_W-1:0]    rd_off;
   logic                        div_done;
   logic [kis_pkg::PROD_W-1:0]  div_quo;
   logic [kis_pkg::PROG_W-1:0]  prog_new;

   assign f_stype = req_tdata[15:0];
   assign f_flags = req_tdata[47:16];
   assign f_ts    = req_tdata[79:48];
   assign f_rlen  = req_tdata[103:80];

   assign req_tready = (state_ff == kis_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign is_key     = (f_stype == vtype_ff) && ((f_flags & kmask_ff) != '0);
   assign wr_en      = accept && (req_tuser == kis_pkg::CMD_RECORD) && is_key &&
                       (count_ff != CW'(INDEX_DEPTH));
   assign wr_data    = {f_ts, len_ff};
   assign rd_off     = rd_data[kis_pkg::TS_W-1:0];
   assign rd_ts      = rd_data[MW-1:kis_pkg::TS_W];
   assign prog_new   = (div_quo >= kis_pkg::PROD_W'(kis_pkg::PROGRESS_SCALE)) ?
                       kis_pkg::PROGRESS_MAX :
                       div_quo[kis_pkg::PROG_W-1:0] + 1'b1;

   kis_ram #(
      .WIDTH (MW),
      .DEPTH (INDEX_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (pick_ff),
      .rd_data (rd_data)
   );

   kis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (prod_ff),
      .divisor  (dur_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      latest_in = latest_ff;
      lastp_in  = lastp_ff;
      target_in = target_ff;
      pick_in   = pick_ff;
      take_in   = take_ff;
      soff_in   = soff_ff;
      sts_in    = sts_ff;
      chg_in    = chg_ff;
      full_in   = full_ff;
      prod_in   = prod_ff;
      ovld_in   = ovld_ff & ~rsp_tready;
      odata_in  = odata_ff;
      unique case (state_ff)
         kis_pkg::ST_IDLE: begin
            if (accept) begin
               soff_in   = '0;
               sts_in    = '0;
               chg_in    = 1'b0;
               full_in   = 1'b0;
               target_in = f_ts;
               if (req_tuser == kis_pkg::CMD_RECORD) begin
                  latest_in = f_ts;
                  len_in    = len_ff + kis_pkg::LEN_W'(f_rlen);
                  // Timestamp times 1000 as 1024 - 16 - 8.
                  prod_in   = {f_ts, 10'd0} - {6'd0, f_ts, 4'd0} - {7'd0, f_ts, 3'd0};
                  if (is_key) begin
                     if (count_ff != CW'(INDEX_DEPTH)) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  state_in = (dur_ff != '0) ? kis_pkg::ST_DIV : kis_pkg::ST_OUT;
               end else if (count_ff != '0) begin
                  pick_in  = AW'(count_ff - 1'b1);
                  take_in  = (f_ts > latest_ff);
                  state_in = kis_pkg::ST_RD;
               end else begin
                  state_in = kis_pkg::ST_OUT;
               end
            end
         end
         kis_pkg::ST_DIV: begin
            if (div_done) begin
               if (prog_new != lastp_ff) begin
                  lastp_in = prog_new;
                  chg_in   = 1'b1;
               end
               state_in = kis_pkg::ST_OUT;
            end
         end
         kis_pkg::ST_RD: begin
            state_in = kis_pkg::ST_CMP;
         end
         kis_pkg::ST_CMP: begin
            if (take_ff || (rd_ts < target_ff) || (pick_ff == '0)) begin
               soff_in  = rd_off;
               sts_in   = rd_ts;
               state_in = kis_pkg::ST_OUT;
            end else begin
               pick_in  = pick_ff - 1'b1;
               state_in = kis_pkg::ST_RD;
            end
         end
         kis_pkg::ST_OUT: begin
            if (!ovld_ff || rsp_tready) begin
               ovld_in  = 1'b1;
               odata_in = {4'b0000, len_ff, full_ff, chg_ff, lastp_ff, sts_ff, soff_ff};
               state_in = kis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kis_pkg::ST_IDLE;
         vtype_ff  <= 16'd1;
         kmask_ff  <= 32'd1;
         dur_ff    <= kis_pkg::DURATION_RESET;
         count_ff  <= '0;
         len_ff    <= '0;
         latest_ff <= '0;
         lastp_ff  <= '0;
         ovld_ff   <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         latest_ff <= latest_in;
         lastp_ff  <= lastp_in;
         ovld_ff   <= ovld_in;
         div_go_ff <= accept && (req_tuser == kis_pkg::CMD_RECORD) && (dur_ff != '0);
         if (csr_we) begin
            unique case (csr_addr)
               kis_pkg::REG_VIDEO_TYPE: vtype_ff <= csr_wdata[kis_pkg::STYPE_W-1:0];
               kis_pkg::REG_KEY_MASK:   kmask_ff <= csr_wdata;
               kis_pkg::REG_DURATION:   dur_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      target_ff <= target_in;
      pick_ff   <= pick_in;
      take_ff   <= take_in;
      soff_ff   <= soff_in;
      sts_ff    <= sts_in;
      chg_ff    <= chg_in;
      full_ff   <= full_in;
      prod_ff   <= prod_in;
      odata_ff  <= odata_in;
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;

endmodule

### design/kis_checker.sv
// ----------------------------------------------------------------------------
// kis_checker
// Port-level checks for the keyframe index and seek block.
// ----------------------------------------------------------------------------
module kis_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [kis_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid after reset.");

   a_prog: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[73:64] <= kis_pkg::PROGRESS_MAX)
      else $error("Progress out of range.");

   a_record: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[74] || rsp_tdata[75]) |-> rsp_tdata[63:0] == '0)
      else $error("Record result carries a seek answer.");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second request taken while one is in work.");

endmodule

bind keyframe_index_seek kis_checker u_kis_checker (.*);
